### src/lcbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbp_pkg: shared types and codes of the LED command byte parser
// Command codes, result kinds, argument counts and the decoder result record.
// ----------------------------------------------------------------------------
package lcbp_pkg;

   // command codes recognized while idle
   localparam logic [7:0] OP_HELLO      = 8'd1;
   localparam logic [7:0] OP_SELF_TEST  = 8'd2;
   localparam logic [7:0] OP_CLEAR_SHOW = 8'd3;
   localparam logic [7:0] OP_SHOW       = 8'd4;
   localparam logic [7:0] OP_SET_LED    = 8'd5;
   localparam logic [7:0] OP_FADE_LED   = 8'd6;

   // argument bytes that follow a set or fade command
   localparam logic [2:0] SET_ARG_BYTES  = 3'd4;
   localparam logic [2:0] FADE_ARG_BYTES = 3'd6;

   // countdown values at which argument bytes are stored
   localparam logic [2:0] LEFT_FADE_ID     = 3'd5;
   localparam logic [2:0] LEFT_FADE_DUR_HI = 3'd4;
   localparam logic [2:0] LEFT_ID          = 3'd3; // set id, fade duration low
   localparam logic [2:0] LEFT_LAST_LEVEL  = 3'd2;

   typedef enum logic [2:0] {
      KIND_INIT  = 3'd0,
      KIND_SHOW  = 3'd1,
      KIND_CLEAR = 3'd2,
      KIND_TEST  = 3'd3,
      KIND_SET   = 3'd4,
      KIND_FADE  = 3'd5
   } kind_type;

   typedef struct packed {
      logic        emit;
      kind_type    kind;
      logic [8:0]  channel;
      logic [7:0]  level;
      logic [15:0] fade_time;
   } result_type;

endpackage
`default_nettype wire

### src/lcbp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbp_req_if: received byte channel
// Valid/ready channel that carries one command or argument byte.
// ----------------------------------------------------------------------------
interface lcbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### src/lcbp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbp_rsp_if: LED action channel
// Valid/ready channel that carries one decoded LED driver action.
// ----------------------------------------------------------------------------
interface lcbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [8:0]  channel;
   logic [7:0]  level;
   logic [15:0] fade_time;

   modport source (output valid, output kind, output channel, output level,
                   output fade_time, input ready);
   modport sink   (input valid, input kind, input channel, input level,
                   input fade_time, output ready);
endinterface
`default_nettype wire

### src/lcbp_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcbp_decoder: command state and byte decode
// Holds the pending command state and decodes one byte into at most one action.
// ----------------------------------------------------------------------------
module lcbp_decoder #(
   parameter int CHANNEL_STRIDE = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           rx_byte,
   output lcbp_pkg::result_type      result
);
   import lcbp_pkg::*;

   localparam logic [8:0] STRIDE_ONE = 9'(CHANNEL_STRIDE);
   localparam logic [8:0] STRIDE_TWO = 9'(2 * CHANNEL_STRIDE);

   logic        fade_mode_ff,  fade_mode_in;
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  base_id_ff,    base_id_in;
   logic [15:0] duration_ff,   duration_in;

   logic [2:0]  left_dec;
   logic [8:0]  offset;

   assign left_dec = bytes_left_ff - 3'd1;

   always_comb begin
      case (left_dec[1:0])
         2'd1:    offset = STRIDE_ONE;
         2'd2:    offset = STRIDE_TWO;
         default: offset = 9'd0;
      endcase
   end

   always_comb begin
      fade_mode_in  = fade_mode_ff;
      bytes_left_in = bytes_left_ff;
      base_id_in    = base_id_ff;
      duration_in   = duration_ff;
      result        = '0;
      result.kind   = KIND_INIT;

      if (bytes_left_ff == 3'd0) begin
         case (rx_byte)
            OP_HELLO: begin
               result.emit = 1'b1;
               result.kind = KIND_INIT;
            end
            OP_SHOW: begin
               result.emit = 1'b1;
               result.kind = KIND_SHOW;
            end
            OP_CLEAR_SHOW: begin
               result.emit = 1'b1;
               result.kind = KIND_CLEAR;
            end
            OP_SELF_TEST: begin
               result.emit = 1'b1;
               result.kind = KIND_TEST;
            end
            OP_SET_LED: begin
               fade_mode_in  = 1'b0;
               bytes_left_in = SET_ARG_BYTES;
            end
            OP_FADE_LED: begin
               fade_mode_in  = 1'b1;
               bytes_left_in = FADE_ARG_BYTES;
            end
            default: ;
         endcase
      end else begin
         bytes_left_in = left_dec;
         if (!fade_mode_ff) begin
            if (left_dec == LEFT_ID) begin
               base_id_in = rx_byte;
            end else if (left_dec <= LEFT_LAST_LEVEL) begin
               result.emit    = 1'b1;
               result.kind    = KIND_SET;
               result.channel = {1'b0, base_id_ff} + offset;
               result.level   = rx_byte;
            end
         end else begin
            if (left_dec == LEFT_FADE_ID) begin
               base_id_in = rx_byte;
            end else if (left_dec == LEFT_FADE_DUR_HI) begin
               duration_in = {rx_byte, 8'd0};
            end else if (left_dec == LEFT_ID) begin
               duration_in = {duration_ff[15:8], duration_ff[7:0] | rx_byte};
            end else if (left_dec <= LEFT_LAST_LEVEL) begin
               result.emit      = 1'b1;
               result.kind      = KIND_FADE;
               result.channel   = {1'b0, base_id_ff} + offset;
               result.level     = rx_byte;
               result.fade_time = duration_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_mode_ff  <= 1'b0;
         bytes_left_ff <= 3'd0;
         base_id_ff    <= 8'd0;
         duration_ff   <= 16'd0;
      end else if (step) begin
         fade_mode_ff  <= fade_mode_in;
         bytes_left_ff <= bytes_left_in;
         base_id_ff    <= base_id_in;
         duration_ff   <= duration_in;
      end
   end

endmodule
`default_nettype wire

### src/led_command_byte_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_command_byte_parser: LED driver command stream parser
// Turns a stream of received bytes into LED driver actions.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one received byte per transaction. rsp_chan carries one
//   action per transaction: reply init, show, clear and show, start test,
//   set LED or fade LED, with target channel, level and fade time.
//   Bytes that start a multi-byte command, argument bytes that only store an
//   id or a duration, and unknown command bytes produce no action.
// Path: an accepted byte waits in the input register, is decoded from it and
//   its action is loaded into the result register when that register is free
//   or being drained; rsp_chan shows the action from the result register.
// Throughput: one byte per cycle unless rsp_chan holds off a waiting action,
//   set by the single decode pass between the input and result registers.
// Reset: synchronous, active high; clears the valid flags of both registers
//   and returns the parser to idle with no pending command.
// Stall: while rsp_chan is held off with an action waiting, one more byte is
//   taken if the input register is empty; then req_chan.ready drops until
//   the waiting action is taken.
// ----------------------------------------------------------------------------
module led_command_byte_parser #(
   parameter int CHANNEL_STRIDE = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   lcbp_req_if.sink      req_chan,
   lcbp_rsp_if.source    rsp_chan
);
   import lcbp_pkg::*;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   // result register
   logic        out_valid_ff;
   result_type  out_ff;

   result_type  decoded;
   logic        advance;
   logic        step;

   // advance the pipeline when the result register is free or being drained
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign step    = advance && in_valid_ff;

   assign req_chan.ready = !in_valid_ff || advance;

   lcbp_decoder #(
      .CHANNEL_STRIDE (CHANNEL_STRIDE)
   ) u_decoder (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (decoded)
   );

   // hold the byte until the decode pass may consume it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // load the action; drop the slot when the byte produced none
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step && decoded.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= decoded;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kind      = out_ff.kind;
   assign rsp_chan.channel   = out_ff.channel;
   assign rsp_chan.level     = out_ff.level;
   assign rsp_chan.fade_time = out_ff.fade_time;

endmodule
`default_nettype wire

### test/tb_led_command_byte_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_command_byte_parser: self-checking bench for the LED command parser
// Feeds command and argument bytes through the request channel and keeps its
// own model of the parser state. Each LED action that leaves the block is
// compared, field by field, with the oldest predicted action. Both channels
// idle at random, with stretches of full-rate flow in between.
// ----------------------------------------------------------------------------
module tb_led_command_byte_parser;
   import lcbp_pkg::*;

   localparam int CHANNEL_STRIDE = 16;
   localparam int RANDOM_BYTES   = 1900;
   localparam int MAX_GAP        = 4;
   localparam int DRAIN_CYCLES   = 8;   // result path is two registers deep

   // One predicted LED driver action.
   typedef struct {
      kind_type    kind;
      logic [8:0]  channel;
      logic [7:0]  level;
      logic [15:0] fade_time;
   } led_action_type;

   logic clock = 1'b0;
   logic reset;

   lcbp_req_if req_chan ();
   lcbp_rsp_if rsp_chan ();

   led_command_byte_parser #(
      .CHANNEL_STRIDE(CHANNEL_STRIDE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Parser state as the bench tracks it.
   logic        pend_fade;
   logic [2:0]  args_left;
   logic [7:0]  led_base;
   logic [15:0] fade_len;

   led_action_type pending_actions[$];
   int             mismatch_count = 0;
   bit             steady_flow    = 1'b0;   // set: neither side idles

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic void push_action(kind_type kind, logic [8:0] channel,
                                       logic [7:0] level, logic [15:0] fade_time);
      led_action_type act;
      act.kind      = kind;
      act.channel   = channel;
      act.level     = level;
      act.fade_time = fade_time;
      pending_actions.push_back(act);
   endfunction

   // Advance the parser by one accepted byte and queue the action it causes.
   function automatic void parse_byte(logic [7:0] b);
      logic [8:0] chan;
      if (args_left == 3'd0) begin
         case (b)
            OP_HELLO:      push_action(KIND_INIT, 9'd0, 8'd0, 16'd0);
            OP_SHOW:       push_action(KIND_SHOW, 9'd0, 8'd0, 16'd0);
            OP_CLEAR_SHOW: push_action(KIND_CLEAR, 9'd0, 8'd0, 16'd0);
            OP_SELF_TEST:  push_action(KIND_TEST, 9'd0, 8'd0, 16'd0);
            OP_SET_LED: begin
               pend_fade = 1'b0;
               args_left = SET_ARG_BYTES;
            end
            OP_FADE_LED: begin
               pend_fade = 1'b1;
               args_left = FADE_ARG_BYTES;
            end
            default: ;   // unknown command: stay idle, emit nothing
         endcase
         return;
      end

      // Argument byte: taken whatever its value, even a command code.
      args_left = args_left - 3'd1;
      // Levels go to base + 2*stride, base + stride, then base; wrap to 9 bits.
      chan = 9'(int'(led_base) + CHANNEL_STRIDE * int'(args_left));
      if (!pend_fade) begin
         if (args_left == LEFT_ID)
            led_base = b;
         else if (args_left <= LEFT_LAST_LEVEL)
            push_action(KIND_SET, chan, b, 16'd0);
      end else begin
         case (args_left)
            LEFT_FADE_ID:     led_base = b;
            LEFT_FADE_DUR_HI: fade_len = {b, 8'h00};
            LEFT_ID:          fade_len[7:0] = b;
            default: begin
               if (args_left <= LEFT_LAST_LEVEL)
                  push_action(KIND_FADE, chan, b, fade_len);
            end
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Send one byte: idle a random number of cycles, then hold valid until the
   // transaction is taken. Valid stays high on return so that a following
   // byte can go out back to back.
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      parse_byte(b);
   endtask

   // Send a complete set-LED or fade-LED command with its arguments.
   task automatic send_led_command(bit fade, logic [7:0] id, logic [15:0] dur,
                                   logic [7:0] lvl_hi, logic [7:0] lvl_mid,
                                   logic [7:0] lvl_lo);
      send_byte(fade ? OP_FADE_LED : OP_SET_LED);
      send_byte(id);
      if (fade) begin
         send_byte(dur[15:8]);
         send_byte(dur[7:0]);
      end
      send_byte(lvl_hi);
      send_byte(lvl_mid);
      send_byte(lvl_lo);
   endtask

   // ------------------------------------------------------------------------
   // Result side: draw a stall per transaction, then check what arrives.
   // ------------------------------------------------------------------------
   task automatic check_field(string name, int expected, int actual);
      if (expected !== actual) begin
         mismatch_count++;
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name,
                  expected, actual);
      end
   endtask

   initial begin
      int             stall;
      led_action_type exp;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (pending_actions.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected action, kind %0d channel %0d level %0d time %0d",
                     $time, rsp_chan.kind, rsp_chan.channel, rsp_chan.level,
                     rsp_chan.fade_time);
         end else begin
            exp = pending_actions.pop_front();
            check_field("kind", int'(exp.kind), int'(rsp_chan.kind));
            check_field("channel", int'(exp.channel), int'(rsp_chan.channel));
            check_field("level", int'(exp.level), int'(rsp_chan.level));
            check_field("fade_time", int'(exp.fade_time), int'(rsp_chan.fade_time));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Single-byte commands that act at once.
   task automatic test_immediate_commands();
      send_byte(OP_HELLO);
      send_byte(OP_SELF_TEST);
      send_byte(OP_CLEAR_SHOW);
      send_byte(OP_SHOW);
   endtask

   // Unknown codes at both ends of the range and just past the last command.
   task automatic test_unknown_commands();
      send_byte(8'h00);
      send_byte(8'h07);
      send_byte(8'hFF);
   endtask

   // Highest base id reaches the top channel; levels at both extremes.
   task automatic test_set_led();
      send_led_command(1'b0, 8'hFF, 16'd0, 8'h00, 8'hFF, 8'h80);
   endtask

   // Full-scale duration with base id zero.
   task automatic test_fade_led();
      send_led_command(1'b1, 8'h00, 16'hFFFF, 8'hFF, 8'h01, 8'h00);
   endtask

   // Command codes in argument position must be taken as plain arguments.
   task automatic test_argument_codes();
      send_led_command(1'b0, OP_FADE_LED, 16'd0, OP_HELLO, OP_SHOW, OP_SET_LED);
   endtask

   // Mostly well-formed commands with random content, single-byte commands,
   // some bare command bytes with short argument runs, and unknown codes as
   // noise. Noise does not count toward the byte budget.
   task automatic test_random_stream();
      int          counted;
      int          sel;
      int          extra;
      logic [15:0] dur;
      counted = 0;
      while (counted < RANDOM_BYTES) begin
         // Flip between idling and full-rate flow now and then.
         if ($urandom_range(0, 63) == 0)
            steady_flow = !steady_flow;
         sel = $urandom_range(0, 99);
         dur = 16'($urandom);
         if (sel < 35) begin
            send_led_command(1'b0, 8'($urandom), dur, 8'($urandom), 8'($urandom),
                             8'($urandom));
            counted += 5;
         end else if (sel < 70) begin
            send_led_command(1'b1, 8'($urandom), dur, 8'($urandom), 8'($urandom),
                             8'($urandom));
            counted += 7;
         end else if (sel < 78) begin
            // Bare command start; whatever follows is taken as its arguments.
            send_byte($urandom_range(0, 1) ? OP_FADE_LED : OP_SET_LED);
            extra = $urandom_range(0, 3);
            repeat (extra) send_byte(8'($urandom));
            counted += 1 + extra;
         end else if (sel < 92) begin
            send_byte(8'($urandom_range(int'(OP_HELLO), int'(OP_SHOW))));
            counted++;
         end else begin
            send_byte($urandom_range(0, 3) == 0 ? 8'h00
                                                : 8'($urandom_range(7, 255)));
         end
      end
      steady_flow = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      pend_fade        = 1'b0;
      args_left        = 3'd0;
      led_base         = 8'h00;
      fade_len         = 16'h0000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_immediate_commands();
      test_unknown_commands();
      test_set_led();
      test_fade_led();
      test_argument_codes();
      test_random_stream();

      // Drop valid, drain the outstanding actions, then let the pipe settle.
      req_chan.valid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
src/lcbp_pkg.sv
src/lcbp_req_if.sv
src/lcbp_rsp_if.sv
src/lcbp_decoder.sv
src/led_command_byte_parser.sv
test/tb_led_command_byte_parser.sv
